[src/assert_macros.svh]
// Assertion macros shared by the rhythm step sequencer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RSQ_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsq: same-cycle check failed");

// Next-cycle implication.
`define RSQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsq: next-cycle check failed");

`endif

[src/rsq_pkg.sv]
// Types, constants and elaboration-time tables for the rhythm step sequencer.
// No dependencies; used by every module of the block.
package rsq_pkg;

   localparam int STEP_COUNT = 16;
   localparam int STEP_W     = 4;
   localparam int DT_W       = 16;
   localparam int ENV_W      = 16;
   localparam int HOLD_W     = 24;
   localparam int LEVEL_W    = 16;
   localparam int OUT_BIN_W  = 3;
   localparam int TEMPO_W    = 9;
   localparam int CTRL_W     = 13;
   localparam int LIST_W     = 40;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int BW_W       = 21;
   localparam int BL_W       = 25;
   localparam int PW_W       = 37;
   localparam int PS_W       = 24;
   localparam int MIX_W      = 38;
   localparam int LEN_W      = 33;
   localparam int DVD_W      = 37;
   localparam int DVS_W      = 16;
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = 1;
   localparam int Q_CNT_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_LIST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRP_LIST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WT_LOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WT_HIGH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_LOW   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_HIGH  = 3'd7;

   localparam logic [CTRL_W-1:0]  CTRL_RESET  = 13'd2053;
   localparam logic [TEMPO_W-1:0] TEMPO_RESET = 9'd120;
   localparam logic [LIST_W-1:0]  DIV_RESET   = 40'd260;
   localparam logic [LIST_W-1:0]  GRP_RESET   = 40'd4327523;

   localparam logic [1:0] STRAT_DIVISIVE = 2'd0;
   localparam logic [1:0] STRAT_ADDITIVE = 2'd1;

   localparam logic [ENV_W-1:0]   LEVEL_MAX  = 16'd32768;
   localparam logic [HOLD_W-1:0]  HOLD_MAX   = 24'hFFFFFF;
   localparam logic [15:0]        MIX_BASE   = 16'd38011;
   localparam logic [15:0]        MIX_STEP   = 16'd55706;
   localparam logic [BW_W-1:0]    ACCENT_EVEN = 21'd65536;
   localparam logic [BW_W-1:0]    ACCENT_ODD  = 21'd49152;
   localparam logic [7:0]         WEIGHT_MAX = 8'd128;
   localparam logic [7:0]         LEN_MIN    = 8'd6;
   localparam logic [7:0]         LEN_MAX    = 8'd192;
   localparam logic [LEN_W-1:0]   LEN_FLOOR  = 33'd8388608;
   localparam logic [31:0]        RECIP_15   = 32'h88888889;
   localparam logic [3:0]         MAX_FIRES  = 4'd8;

   typedef struct packed {
      logic [CTRL_W-1:0]  control;
      logic [TEMPO_W-1:0] tempo;
      logic [LIST_W-1:0]  div_list;
      logic [LIST_W-1:0]  grp_list;
      logic [63:0]        wt_lo;
      logic [63:0]        wt_hi;
      logic [63:0]        ln_lo;
      logic [63:0]        ln_hi;
   } cfg_type;

   typedef struct packed {
      logic [DT_W-1:0] dt;
      logic            is_zero;
   } tick_type;

   typedef struct packed {
      logic               full;
      logic               empty;
      logic [Q_CNT_W-1:0] count;
   } q_stat_type;

   // Shift-subtract quotient, used only while building tables.
   function automatic int unsigned const_quot(int unsigned num, int unsigned den);
      int unsigned     q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         q = {q[30:0], 1'b0};
         if (r >= longint'(den)) begin
            r = r - longint'(den);
            q = q | 32'd1;
         end
      end
      return q;
   endfunction

   // exp(-11 * 2^-16 * 2^k) in Q0.32, rounded squaring chain.
   function automatic logic [STEP_COUNT-1:0][31:0] decay_table();
      logic [STEP_COUNT-1:0][31:0] t;
      logic [63:0] b;
      b = 64'd4294246460;
      for (int k = 0; k < STEP_COUNT; k++) begin
         t[k] = b[31:0];
         b = (b * b + 64'h80000000) >> 32;
      end
      return t;
   endfunction

   function automatic logic [31:0][16:0] div_weight_table();
      logic [31:0][16:0] t;
      t = '0;
      for (int d = 1; d < 32; d++) begin
         t[d] = 17'(45875 + const_quot(39322 + (d >> 1), d));
      end
      return t;
   endfunction

   function automatic logic [31:0][20:0] div_len_table();
      logic [31:0][20:0] t;
      int l;
      t = '0;
      for (int d = 1; d < 32; d++) begin
         l = int'(const_quot(1048576 + (d >> 1), d));
         if (l < 65536) begin
            l = 65536;
         end
         t[d] = 21'(l);
      end
      return t;
   endfunction

endpackage

[src/rsq_front.sv]
// Input stage: takes tick transactions and tags zero ticks.
// Depends on rsq_pkg; feeds rsq_queue.
module rsq_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [rsq_pkg::DT_W-1:0]  req_elapsed_time,
   input  logic                      q_full,
   output logic                      push,
   output rsq_pkg::tick_type         push_data
);

   logic              hold_valid_ff, hold_valid_in;
   rsq_pkg::tick_type hold_data_ff, hold_data_in;
   logic              accept;

   assign push      = hold_valid_ff && !q_full;
   assign req_ready = !hold_valid_ff || !q_full;
   assign accept    = req_valid && req_ready;
   assign push_data = hold_data_ff;

   always_comb begin
      hold_valid_in = accept || (hold_valid_ff && !push);
      hold_data_in  = hold_data_ff;
      if (accept) begin
         hold_data_in.dt      = req_elapsed_time;
         hold_data_in.is_zero = (req_elapsed_time == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_data_ff <= hold_data_in;
   end

endmodule

[src/rsq_queue.sv]
// Two-entry queue of classified ticks between front and back.
// Depends on rsq_pkg.
module rsq_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rsq_pkg::tick_type   push_data,
   input  logic                pop,
   output rsq_pkg::tick_type   pop_data,
   output rsq_pkg::q_stat_type stat
);

   rsq_pkg::tick_type                  slot_ff [rsq_pkg::Q_DEPTH];
   logic [rsq_pkg::Q_PTR_W-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [rsq_pkg::Q_CNT_W-1:0]        cnt_ff, cnt_in;

   assign pop_data   = slot_ff[rd_ff];
   assign stat.full  = (cnt_ff == rsq_pkg::Q_CNT_W'(rsq_pkg::Q_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign stat.count = cnt_ff;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[src/rsq_div.sv]
// Restoring divider, one quotient bit per cycle, for the hold time.
// Depends on rsq_pkg.
module rsq_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rsq_pkg::DVD_W-1:0]  dividend,
   input  logic [rsq_pkg::DVS_W-1:0]  divisor,
   output logic                       done,
   output logic [rsq_pkg::DVD_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(rsq_pkg::DVD_W + 1);

   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [rsq_pkg::DVS_W-1:0]     rem_ff, rem_in, dvs_ff, dvs_in;
   logic [rsq_pkg::DVD_W-1:0]     quo_ff, quo_in;
   logic [rsq_pkg::DVS_W:0]       shifted;
   logic [rsq_pkg::DVS_W+1:0]     diff;

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign shifted  = {rem_ff, quo_ff[rsq_pkg::DVD_W-1]};
   assign diff     = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in = CNT_W'(rsq_pkg::DVD_W);
         run_in = 1'b1;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         if (!diff[rsq_pkg::DVS_W+1]) begin
            rem_in = diff[rsq_pkg::DVS_W-1:0];
            quo_in = {quo_ff[rsq_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[rsq_pkg::DVS_W-1:0];
            quo_in = {quo_ff[rsq_pkg::DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

[src/rsq_back.sv]
// Tick engine: decay, phase advance, onset scan per crossed step, level output.
// Depends on rsq_pkg; drives rsq_div and the result output register.
module rsq_back #(
   parameter int BIN_COUNT  = 8,
   parameter int LIST_SLOTS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rsq_pkg::cfg_type           cfg,
   input  logic                       clear_run,
   input  logic                       q_valid,
   input  rsq_pkg::tick_type          q_data,
   output logic                       q_pop,
   output logic                       div_start,
   output logic [rsq_pkg::DVD_W-1:0]  div_dividend,
   output logic [rsq_pkg::DVS_W-1:0]  div_divisor,
   input  logic                       div_done,
   input  logic [rsq_pkg::DVD_W-1:0]  div_quotient,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rsq_pkg::OUT_BIN_W-1:0] rsp_bin_number,
   output logic [rsq_pkg::LEVEL_W-1:0]   rsp_bin_level,
   output logic                       rsp_last_bin
);

   localparam int BIN_W  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam int SLOT_W = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
   localparam int SW     = rsq_pkg::STEP_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FACT  = 4'd1;
   localparam logic [3:0] ST_DECAY = 4'd2;
   localparam logic [3:0] ST_SCAN  = 4'd3;
   localparam logic [3:0] ST_MUL1  = 4'd4;
   localparam logic [3:0] ST_MUL2  = 4'd5;
   localparam logic [3:0] ST_MUL3  = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;

   function automatic logic [rsq_pkg::STEP_COUNT-1:0][BIN_W-1:0] bin_table();
      logic [rsq_pkg::STEP_COUNT-1:0][BIN_W-1:0] t;
      int v;
      for (int s = 0; s < rsq_pkg::STEP_COUNT; s++) begin
         v = s;
         while (v >= BIN_COUNT) begin
            v = v - BIN_COUNT;
         end
         t[s] = BIN_W'(v);
      end
      return t;
   endfunction

   localparam logic [rsq_pkg::STEP_COUNT-1:0][31:0] DECAY_TAB = rsq_pkg::decay_table();
   localparam logic [31:0][16:0] DIV_W_TAB = rsq_pkg::div_weight_table();
   localparam logic [31:0][20:0] DIV_L_TAB = rsq_pkg::div_len_table();
   localparam logic [rsq_pkg::STEP_COUNT-1:0][BIN_W-1:0] BIN_OF = bin_table();

   logic [3:0]                    state_ff, state_in;
   logic [rsq_pkg::DT_W-1:0]      dt_ff, dt_in;
   logic                          zero_ff, zero_in;
   logic [SW-1:0]                 k_ff, k_in;
   logic [31:0]                   f_ff, f_in;
   logic                          f_one_ff, f_one_in;
   logic [24:0]                   prod_ff, prod_in;
   logic [21:0]                   quot_ff, quot_in;
   logic [BIN_W-1:0]              idx_ff, idx_in;
   logic [rsq_pkg::ENV_W-1:0]     env_ff [BIN_COUNT];
   logic [rsq_pkg::ENV_W-1:0]     env_in [BIN_COUNT];
   logic [rsq_pkg::HOLD_W-1:0]    hold_ff [BIN_COUNT];
   logic [rsq_pkg::HOLD_W-1:0]    hold_in [BIN_COUNT];
   logic [SW-1:0]                 phase_step_ff, phase_step_in;
   logic [15:0]                   phase_frac_ff, phase_frac_in;
   logic [3:0]                    fire_cnt_ff, fire_cnt_in;
   logic [SW-1:0]                 step_ff, step_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic [SW-1:0]                 cursor_ff, cursor_in;
   logic                          onset_ff, onset_in;
   logic [rsq_pkg::BW_W-1:0]      bw_ff, bw_in;
   logic [rsq_pkg::BL_W-1:0]      bl_ff, bl_in;
   logic [rsq_pkg::PW_W-1:0]      pw_ff, pw_in;
   logic [rsq_pkg::PS_W-1:0]      ps_ff, ps_in;
   logic [rsq_pkg::LEN_W-1:0]     len_ff, len_in;
   logic [rsq_pkg::MIX_W-1:0]     mix_ff, mix_in;
   logic [rsq_pkg::ENV_W-1:0]     new_env_ff, new_env_in;
   logic                          out_valid_ff, out_valid_in;
   logic [rsq_pkg::OUT_BIN_W-1:0] out_bin_ff, out_bin_in;
   logic [rsq_pkg::LEVEL_W-1:0]   out_level_ff, out_level_in;
   logic                          out_last_ff, out_last_in;

   logic [rsq_pkg::ENV_W-1:0]     env_rd;
   logic [rsq_pkg::HOLD_W-1:0]    hold_rd;
   logic [47:0]                   env_prod;
   logic [63:0]                   f_prod;
   logic [56:0]                   recip_prod;
   logic [21:0]                   total;
   logic [5:0]                    crossed;
   logic [4:0]                    d_val, g_val;
   logic [8:0]                    step_d;
   logic                          use_div, use_add, div_hit, add_hit, onset_now;
   logic [rsq_pkg::BW_W-1:0]      bw_next;
   logic [rsq_pkg::BL_W-1:0]      bl_next;
   logic [63:0]                   wt_src, ln_src;
   logic [7:0]                    sw_raw, sl_raw, sw_val, sl_val;
   logic [47:0]                   env_full;
   logic [rsq_pkg::HOLD_W-1:0]    hold_new;
   logic                          adv, start_scan, load_out, last_idx;
   logic [SW-1:0]                 scan_step;

   assign env_rd     = env_ff[idx_ff];
   assign hold_rd    = hold_ff[idx_ff];
   assign env_prod   = env_rd * f_ff + 48'h80000000;
   assign f_prod     = f_ff * DECAY_TAB[k_ff] + 64'h80000000;
   assign recip_prod = prod_ff * rsq_pkg::RECIP_15;
   assign total      = 22'(phase_frac_ff) + quot_ff;
   assign crossed    = total[21:16];

   assign use_div = (cfg.control[2:1] != rsq_pkg::STRAT_ADDITIVE);
   assign use_add = (cfg.control[2:1] != rsq_pkg::STRAT_DIVISIVE);
   assign d_val   = cfg.div_list[slot_ff * 5 +: 5];
   assign g_val   = cfg.grp_list[slot_ff * 5 +: 5];
   assign step_d  = step_ff * d_val;
   assign div_hit = use_div && (d_val != '0) && (step_d[3:0] == '0);
   assign add_hit = use_add && (g_val != '0) && (step_ff == cursor_ff);
   assign onset_now = onset_ff || div_hit || add_hit;

   always_comb begin
      bw_next = bw_ff;
      bl_next = bl_ff;
      if (div_hit) begin
         bw_next = bw_next + rsq_pkg::BW_W'(DIV_W_TAB[d_val]);
         bl_next = bl_next + rsq_pkg::BL_W'(DIV_L_TAB[d_val]);
      end
      if (add_hit) begin
         bw_next = bw_next + (slot_ff[0] ? rsq_pkg::ACCENT_ODD : rsq_pkg::ACCENT_EVEN);
         bl_next = bl_next + rsq_pkg::BL_W'({g_val, 16'h0000});
      end
   end

   assign wt_src = step_ff[SW-1] ? cfg.wt_hi : cfg.wt_lo;
   assign ln_src = step_ff[SW-1] ? cfg.ln_hi : cfg.ln_lo;
   assign sw_raw = wt_src[step_ff[2:0] * 8 +: 8];
   assign sl_raw = ln_src[step_ff[2:0] * 8 +: 8];
   assign sw_val = (sw_raw > rsq_pkg::WEIGHT_MAX) ? rsq_pkg::WEIGHT_MAX : sw_raw;
   assign sl_val = (sl_raw < rsq_pkg::LEN_MIN) ? rsq_pkg::LEN_MIN :
                   (sl_raw > rsq_pkg::LEN_MAX) ? rsq_pkg::LEN_MAX : sl_raw;

   assign env_full     = mix_ff * cfg.control[12:3] + 48'h1000000;
   assign div_dividend = {len_ff, 4'h0} - rsq_pkg::DVD_W'(len_ff);
   assign div_divisor  = {cfg.tempo, 7'h00};
   assign hold_new     = (div_quotient > rsq_pkg::DVD_W'(rsq_pkg::HOLD_MAX)) ?
                         rsq_pkg::HOLD_MAX : div_quotient[rsq_pkg::HOLD_W-1:0];

   assign last_idx = (idx_ff == BIN_W'(BIN_COUNT - 1));
   assign load_out = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_ready);

   assign rsp_valid      = out_valid_ff;
   assign rsp_bin_number = out_bin_ff;
   assign rsp_bin_level  = out_level_ff;
   assign rsp_last_bin   = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      dt_in         = dt_ff;
      zero_in       = zero_ff;
      k_in          = k_ff;
      f_in          = f_ff;
      f_one_in      = f_one_ff;
      prod_in       = prod_ff;
      quot_in       = quot_ff;
      idx_in        = idx_ff;
      env_in        = env_ff;
      hold_in       = hold_ff;
      phase_step_in = phase_step_ff;
      phase_frac_in = phase_frac_ff;
      fire_cnt_in   = fire_cnt_ff;
      step_in       = step_ff;
      slot_in       = slot_ff;
      cursor_in     = cursor_ff;
      onset_in      = onset_ff;
      bw_in         = bw_ff;
      bl_in         = bl_ff;
      pw_in         = pw_ff;
      ps_in         = ps_ff;
      len_in        = len_ff;
      mix_in        = mix_ff;
      new_env_in    = new_env_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_bin_in    = out_bin_ff;
      out_level_in  = out_level_ff;
      out_last_in   = out_last_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      adv           = 1'b0;
      start_scan    = 1'b0;
      scan_step     = step_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               dt_in   = q_data.dt;
               zero_in = q_data.is_zero;
               idx_in  = '0;
               if (q_data.is_zero) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FACT;
                  k_in     = '0;
                  f_one_in = 1'b1;
               end
            end
         end
         ST_FACT: begin
            if (dt_ff[k_ff]) begin
               f_one_in = 1'b0;
               f_in     = f_one_ff ? DECAY_TAB[k_ff] : f_prod[63:32];
            end
            if (k_ff == SW'(0)) begin
               prod_in = dt_ff * cfg.tempo;
            end
            if (k_ff == SW'(1)) begin
               quot_in = recip_prod[56:35];
            end
            if (k_ff == SW'(2)) begin
               step_in     = phase_step_ff + 1'b1;
               fire_cnt_in = '0;
               if (cfg.control[0]) begin
                  phase_frac_in = total[15:0];
                  phase_step_in = phase_step_ff + crossed[SW-1:0];
                  fire_cnt_in   = (crossed > 6'(rsq_pkg::MAX_FIRES)) ?
                                  rsq_pkg::MAX_FIRES : crossed[3:0];
               end
            end
            k_in = k_ff + 1'b1;
            if (k_ff == SW'(rsq_pkg::STEP_COUNT - 1)) begin
               state_in = ST_DECAY;
               idx_in   = '0;
            end
         end
         ST_DECAY: begin
            env_in[idx_ff]  = env_prod[47:32];
            hold_in[idx_ff] = (hold_rd > rsq_pkg::HOLD_W'(dt_ff)) ?
                              hold_rd - rsq_pkg::HOLD_W'(dt_ff) : '0;
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               if (fire_cnt_ff != '0) begin
                  start_scan = 1'b1;
               end else begin
                  state_in = ST_EMIT;
                  idx_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            bw_in    = bw_next;
            bl_in    = bl_next;
            onset_in = onset_now;
            if (use_add && g_val != '0) begin
               cursor_in = cursor_ff + g_val[SW-1:0];
            end
            slot_in = slot_ff + 1'b1;
            if (slot_ff == SLOT_W'(LIST_SLOTS - 1)) begin
               if (onset_now) begin
                  state_in = ST_MUL1;
               end else begin
                  adv = 1'b1;
               end
            end
         end
         ST_MUL1: begin
            pw_in    = bw_ff * rsq_pkg::MIX_BASE;
            ps_in    = sw_val * rsq_pkg::MIX_STEP;
            len_in   = bl_ff * sl_val;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mix_in = rsq_pkg::MIX_W'(pw_ff) + rsq_pkg::MIX_W'({ps_ff, 10'h000});
            if (len_ff < rsq_pkg::LEN_FLOOR) begin
               len_in = rsq_pkg::LEN_FLOOR;
            end
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            new_env_in = (env_full[47:25] > 23'(16'hFFFF)) ? 16'hFFFF : env_full[40:25];
            div_start  = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (new_env_ff > env_rd) begin
                  env_in[idx_ff] = new_env_ff;
               end
               if (hold_new > hold_rd) begin
                  hold_in[idx_ff] = hold_new;
               end
               adv = 1'b1;
            end
         end
         ST_EMIT: begin
            if (load_out) begin
               out_valid_in = 1'b1;
               out_bin_in   = rsq_pkg::OUT_BIN_W'(idx_ff);
               out_last_in  = last_idx;
               out_level_in = (zero_ff || hold_rd == '0) ? '0 :
                              (env_rd > rsq_pkg::LEVEL_MAX) ? rsq_pkg::LEVEL_MAX : env_rd;
               idx_in = idx_ff + 1'b1;
               if (last_idx) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (adv) begin
         fire_cnt_in = fire_cnt_ff - 1'b1;
         if (fire_cnt_ff == 4'd1) begin
            state_in = ST_EMIT;
            idx_in   = '0;
         end else begin
            start_scan = 1'b1;
            scan_step  = step_ff + 1'b1;
         end
      end
      if (start_scan) begin
         state_in  = ST_SCAN;
         step_in   = scan_step;
         idx_in    = BIN_OF[scan_step];
         slot_in   = '0;
         cursor_in = '0;
         onset_in  = 1'b0;
         bw_in     = '0;
         bl_in     = '0;
      end

      if (clear_run) begin
         phase_step_in = '0;
         phase_frac_in = '0;
         for (int b = 0; b < BIN_COUNT; b++) begin
            env_in[b]  = '0;
            hold_in[b] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_step_ff <= '0;
         phase_frac_ff <= '0;
         fire_cnt_ff   <= '0;
         out_valid_ff  <= 1'b0;
         for (int b = 0; b < BIN_COUNT; b++) begin
            env_ff[b]  <= '0;
            hold_ff[b] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_step_ff <= phase_step_in;
         phase_frac_ff <= phase_frac_in;
         fire_cnt_ff   <= fire_cnt_in;
         out_valid_ff  <= out_valid_in;
         env_ff        <= env_in;
         hold_ff       <= hold_in;
      end
      dt_ff        <= dt_in;
      zero_ff      <= zero_in;
      k_ff         <= k_in;
      f_ff         <= f_in;
      f_one_ff     <= f_one_in;
      prod_ff      <= prod_in;
      quot_ff      <= quot_in;
      idx_ff       <= idx_in;
      step_ff      <= step_in;
      slot_ff      <= slot_in;
      cursor_ff    <= cursor_in;
      onset_ff     <= onset_in;
      bw_ff        <= bw_in;
      bl_ff        <= bl_in;
      pw_ff        <= pw_in;
      ps_ff        <= ps_in;
      len_ff       <= len_in;
      mix_ff       <= mix_in;
      new_env_ff   <= new_env_in;
      out_bin_ff   <= out_bin_in;
      out_level_ff <= out_level_in;
      out_last_ff  <= out_last_in;
   end

endmodule

[src/rsq_top_placeholder_unused.sv]
// Configuration register file of the rhythm step sequencer.
// Depends on rsq_pkg; instantiated by the top level.
module rsq_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rsq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rsq_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output rsq_pkg::cfg_type                  cfg,
   output logic                              clear_run
);

   rsq_pkg::cfg_type cfg_ff, cfg_in;

   assign cfg       = cfg_ff;
   assign clear_run = csr_we && (csr_index == rsq_pkg::CSR_CONTROL) &&
                      cfg_ff.control[0] && !csr_wdata[0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rsq_pkg::CSR_CONTROL:  cfg_in.control  = csr_wdata[rsq_pkg::CTRL_W-1:0];
            rsq_pkg::CSR_TEMPO:    cfg_in.tempo    = csr_wdata[rsq_pkg::TEMPO_W-1:0];
            rsq_pkg::CSR_DIV_LIST: cfg_in.div_list = csr_wdata[rsq_pkg::LIST_W-1:0];
            rsq_pkg::CSR_GRP_LIST: cfg_in.grp_list = csr_wdata[rsq_pkg::LIST_W-1:0];
            rsq_pkg::CSR_WT_LOW:   cfg_in.wt_lo    = csr_wdata;
            rsq_pkg::CSR_WT_HIGH:  cfg_in.wt_hi    = csr_wdata;
            rsq_pkg::CSR_LEN_LOW:  cfg_in.ln_lo    = csr_wdata;
            rsq_pkg::CSR_LEN_HIGH: cfg_in.ln_hi    = csr_wdata;
            default:               cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control  <= rsq_pkg::CTRL_RESET;
         cfg_ff.tempo    <= rsq_pkg::TEMPO_RESET;
         cfg_ff.div_list <= rsq_pkg::DIV_RESET;
         cfg_ff.grp_list <= rsq_pkg::GRP_RESET;
         cfg_ff.wt_lo    <= '0;
         cfg_ff.wt_hi    <= '0;
         cfg_ff.ln_lo    <= '0;
         cfg_ff.ln_hi    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/rhythm_step_envelope_sequencer_core.sv]
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | req_elapsed_time[15:0]
//  rsp     | out       | rsp_valid/ready    | rsp_bin_number, rsp_bin_level, rsp_last_bin
//  csr     | in        | csr_we             | csr_index[2:0], csr_wdata[63:0]
// A zero tick goes from idle straight to output. A nonzero tick runs the decay
// factor over the dt bits (one multiply per cycle), the envelope decay of every
// bin, per fired step a scan of LIST_SLOTS slots and, on an onset, the multiply
// states and the hold divider, then the output of BIN_COUNT bins, stalled while
// rsp_ready is low. Synchronous reset restores the register defaults and clears
// phase, envelopes and holds. The front and a two-entry queue keep taking ticks
// while the back is busy or the result side stalls, until both are full.
`include "assert_macros.svh"

module rhythm_step_envelope_sequencer_core #(
   parameter int BIN_COUNT  = 8,
   parameter int LIST_SLOTS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rsq_pkg::DT_W-1:0]             req_elapsed_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rsq_pkg::OUT_BIN_W-1:0]        rsp_bin_number,
   output logic [rsq_pkg::LEVEL_W-1:0]          rsp_bin_level,
   output logic                                 rsp_last_bin,
   input  logic                                 csr_we,
   input  logic [rsq_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rsq_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   rsq_pkg::cfg_type           cfg;
   logic                       clear_run;
   logic                       q_push, q_pop;
   rsq_pkg::tick_type          q_in, q_out;
   rsq_pkg::q_stat_type        q_stat;
   logic                       div_start, div_done;
   logic [rsq_pkg::DVD_W-1:0]  div_dividend, div_quotient;
   logic [rsq_pkg::DVS_W-1:0]  div_divisor;

   rsq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .clear_run (clear_run)
   );

   rsq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_elapsed_time (req_elapsed_time),
      .q_full           (q_stat.full),
      .push             (q_push),
      .push_data        (q_in)
   );

   rsq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .stat      (q_stat)
   );

   rsq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   rsq_back #(
      .BIN_COUNT  (BIN_COUNT),
      .LIST_SLOTS (LIST_SLOTS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .clear_run      (clear_run),
      .q_valid        (!q_stat.empty),
      .q_data         (q_out),
      .q_pop          (q_pop),
      .div_start      (div_start),
      .div_dividend   (div_dividend),
      .div_divisor    (div_divisor),
      .div_done       (div_done),
      .div_quotient   (div_quotient),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_number (rsp_bin_number),
      .rsp_bin_level  (rsp_bin_level),
      .rsp_last_bin   (rsp_last_bin)
   );

   `RSQ_ASSERT_IMP(a_last_bin_number, clock, reset, rsp_valid && rsp_last_bin, rsp_bin_number == rsq_pkg::OUT_BIN_W'(BIN_COUNT - 1))
   `RSQ_ASSERT_IMP(a_level_clamped, clock, reset, rsp_valid, rsp_bin_level <= rsq_pkg::LEVEL_MAX)
   `RSQ_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, q_stat.count <= rsq_pkg::Q_CNT_W'(rsq_pkg::Q_DEPTH))
   `RSQ_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bin_level))

endmodule

[test/tb_top.sv]
// Testbench for rhythm_step_envelope_sequencer_core: predicts the per-bin levels of
// each tick and compares every rsp transaction against them.
// Depends on rsq_pkg and the core RTL only.
module tb_top;
   import rsq_pkg::*;

   localparam int NBINS = 8;
   localparam logic [1:0] STRAT_HYBRID = 2'd2;
   localparam logic [1:0] STRAT_ALT    = 2'd3;

   typedef struct packed {
      logic [OUT_BIN_W-1:0] bin;
      logic [LEVEL_W-1:0]   level;
      logic                 last;
   } level_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [DT_W-1:0] req_elapsed_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_BIN_W-1:0] rsp_bin_number;
   logic [LEVEL_W-1:0] rsp_bin_level;
   logic rsp_last_bin;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rhythm_step_envelope_sequencer_core dut (.*);

   // predictor copy of registers and state
   logic [CTRL_W-1:0]  ctl_q;
   logic [TEMPO_W-1:0] tempo_q;
   logic [LIST_W-1:0]  div_q, grp_q;
   logic [63:0]        wt_lo_q, wt_hi_q, ln_lo_q, ln_hi_q;
   logic [3:0]         step_q;
   logic [15:0]        frac_q;
   logic [63:0]        env_q [NBINS];
   logic [63:0]        hold_q [NBINS];

   level_type level_queue [$];
   int errors = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("rhythm_step_envelope_sequencer_core: mismatch");
      $finish;
   end

   function automatic void clear_run_state();
      step_q = '0;
      frac_q = '0;
      for (int b = 0; b < NBINS; b++) begin
         env_q[b] = '0;
         hold_q[b] = '0;
      end
   endfunction

   function automatic logic [63:0] decay_mult(logic [15:0] dt);
      logic [63:0] f;
      logic [63:0] base;
      f = 64'h1_0000_0000;
      base = 64'd4294246460;
      for (int k = 0; k < 16; k++) begin
         if (dt[k]) begin
            f = (f * base + 64'h8000_0000) >> 32;
         end
         base = (base * base + 64'h8000_0000) >> 32;
      end
      return f;
   endfunction

   function automatic void trigger_step(int step);
      logic [1:0] strat;
      logic [63:0] bw, bl, cursor, d, g, l, sw, sl, gain, mix, env, len, hold;
      logic onset;
      int bin;
      strat = ctl_q[2:1];
      bw = 0;
      bl = 0;
      cursor = 0;
      onset = 1'b0;
      bin = step % NBINS;
      if (strat != STRAT_ADDITIVE) begin
         for (int i = 0; i < 8; i++) begin
            d = (div_q >> (5 * i)) & 64'd31;
            if (d != 0 && ((step * d) % 16) == 0) begin
               onset = 1'b1;
               bw += 45875 + (39322 + d / 2) / d;
               l = (1048576 + d / 2) / d;
               if (l < 65536) begin
                  l = 65536;
               end
               bl += l;
            end
         end
      end
      if (strat != STRAT_DIVISIVE) begin
         for (int i = 0; i < 8; i++) begin
            g = (grp_q >> (5 * i)) & 64'd31;
            if (g != 0) begin
               if (step == cursor % 16) begin
                  onset = 1'b1;
                  bw += (i % 2) ? 64'd49152 : 64'd65536;
                  bl += g << 16;
               end
               cursor += g;
            end
         end
      end
      if (!onset) begin
         return;
      end
      sw = ((step < 8 ? wt_lo_q : wt_hi_q) >> (8 * (step % 8))) & 64'hFF;
      sl = ((step < 8 ? ln_lo_q : ln_hi_q) >> (8 * (step % 8))) & 64'hFF;
      gain = ctl_q[12:3];
      if (sw > 128) sw = 128;
      if (sl < 6) sl = 6;
      if (sl > 192) sl = 192;
      mix = bw * 38011 + ((sw * 55706) << 10);
      env = (mix * gain + (64'd1 << 24)) >> 25;
      if (env > 65535) env = 65535;
      len = bl * sl;
      if (len < (64'd1 << 23)) len = 64'd1 << 23;
      if (tempo_q == 0) begin
         hold = 64'hFFFFFF;
      end else begin
         hold = (len * 15) / (tempo_q * 128);
      end
      if (hold > 64'hFFFFFF) hold = 64'hFFFFFF;
      if (env > env_q[bin]) env_q[bin] = env;
      if (hold > hold_q[bin]) hold_q[bin] = hold;
   endfunction

   function automatic void predict_levels(logic [15:0] dt);
      logic [63:0] f, total, crossed, fires;
      level_type e;
      if (dt != 0) begin
         f = decay_mult(dt);
         for (int b = 0; b < NBINS; b++) begin
            hold_q[b] = (hold_q[b] > dt) ? hold_q[b] - dt : 0;
            env_q[b] = (env_q[b] * f + 64'h8000_0000) >> 32;
         end
         if (ctl_q[0]) begin
            total = frac_q + (dt * tempo_q) / 15;
            crossed = total >> 16;
            fires = crossed < 8 ? crossed : 8;
            frac_q = total[15:0];
            for (int j = 1; j <= fires; j++) begin
               trigger_step((step_q + j) % 16);
            end
            step_q = step_q + crossed[3:0];
         end
      end
      for (int b = 0; b < NBINS; b++) begin
         e.bin = OUT_BIN_W'(b);
         e.level = '0;
         if (dt != 0 && hold_q[b] > 0) begin
            e.level = env_q[b] > LEVEL_MAX ? LEVEL_MAX : env_q[b][15:0];
         end
         e.last = (b == NBINS - 1);
         level_queue.push_back(e);
      end
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("error: %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      level_type e;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (level_queue.size() == 0) begin
            report("unexpected transaction bin", rsp_bin_number, 0);
         end else begin
            e = level_queue.pop_front();
            if (rsp_bin_number != e.bin) report("bin_number", rsp_bin_number, e.bin);
            if (rsp_bin_level != e.level) report("bin_level", rsp_bin_level, e.level);
            if (rsp_last_bin != e.last) report("last_bin", rsp_last_bin, e.last);
         end
      end
   end

   task automatic send_tick(logic [15:0] dt);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_elapsed_time <= dt;
      do @(posedge clock); while (!req_ready);
      predict_levels(dt);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (level_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CONTROL: begin
            if (ctl_q[0] && !val[0]) clear_run_state();
            ctl_q = val[CTRL_W-1:0];
         end
         CSR_TEMPO:    tempo_q = val[TEMPO_W-1:0];
         CSR_DIV_LIST: div_q = val[LIST_W-1:0];
         CSR_GRP_LIST: grp_q = val[LIST_W-1:0];
         CSR_WT_LOW:   wt_lo_q = val;
         CSR_WT_HIGH:  wt_hi_q = val;
         CSR_LEN_LOW:  ln_lo_q = val;
         CSR_LEN_HIGH: ln_hi_q = val;
      endcase
   endtask

   task automatic csr_done();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [15:0] rand_dt();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'($urandom_range(65535));
         2: return 16'hFFFF;
         default: return 16'($urandom_range(1, 3000));
      endcase
   endfunction

   task automatic test_defaults();
      csr_write(CSR_WT_LOW, 64'h8080_8080_8080_8080);
      csr_write(CSR_WT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_LEN_LOW, 64'h0000_0000_0000_0000);
      csr_write(CSR_LEN_HIGH, 64'hC0C0_C0C0_C0C0_C0C0);
      csr_done();
      send_tick(16'd0);
      send_tick(16'd1);
      send_tick(16'd1092);
      send_tick(16'd8192);
      send_tick(16'd0);
      send_tick(16'hFFFF);
      send_tick(16'd2000);
      drain();
   endtask

   task automatic test_strategies();
      for (int s = 0; s < 4; s++) begin
         csr_write(CSR_CONTROL, {51'd0, 10'h3FF, 2'(s), 1'b1});
         csr_write(CSR_DIV_LIST, 64'hFF_FFFF_FFFF);
         csr_write(CSR_GRP_LIST, {24'd0, 5'd1, 5'd2, 5'd3, 5'd1, 5'd31, 5'd1, 5'd2, 5'd3});
         csr_write(CSR_LEN_LOW, 64'h2040_6080_A0C0_E0FF);
         csr_done();
         send_tick(16'd4000);
         send_tick(16'd30000);
         drain();
      end
   endtask

   task automatic test_tempo_extremes();
      csr_write(CSR_TEMPO, 64'd0);
      csr_write(CSR_CONTROL, {51'd0, 10'd256, STRAT_HYBRID, 1'b1});
      csr_done();
      send_tick(16'd5000);
      send_tick(16'd40000);
      drain();
      csr_write(CSR_TEMPO, 64'd511);
      csr_done();
      send_tick(16'hFFFF);
      send_tick(16'd500);
      drain();
      csr_write(CSR_TEMPO, 64'd30);
      csr_done();
      send_tick(16'd9000);
      drain();
   endtask

   task automatic test_disable();
      csr_write(CSR_TEMPO, 64'd280);
      csr_done();
      send_tick(16'd3000);
      drain();
      csr_write(CSR_CONTROL, {51'd0, 10'd0, STRAT_ALT, 1'b0});
      csr_done();
      send_tick(16'd3000);
      drain();
      csr_write(CSR_CONTROL, {51'd0, 10'd512, STRAT_ALT, 1'b1});
      csr_done();
      send_tick(16'd3000);
      drain();
   endtask

   task automatic test_random();
      int idle_send [4] = '{0, 86, 0, 7};
      int idle_rsp [4] = '{0, 0, 86, 7};
      logic [63:0] ctl;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_send[p];
         rsp_stall_pct = idle_rsp[p];
         for (int r = 0; r < 4; r++) begin
            ctl = rand64();
            ctl[0] = ($urandom_range(4) != 0);
            csr_write(CSR_CONTROL, ctl);
            csr_write(CSR_TEMPO, $urandom_range(9) == 0 ? $urandom_range(511)
                                                        : $urandom_range(30, 280));
            csr_write(CSR_DIV_LIST, rand64());
            csr_write(CSR_GRP_LIST, rand64());
            csr_write(CSR_WT_LOW, rand64());
            csr_write(CSR_WT_HIGH, rand64());
            csr_write(CSR_LEN_LOW, rand64());
            csr_write(CSR_LEN_HIGH, rand64());
            csr_done();
            repeat (8) send_tick(rand_dt());
            drain();
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      ctl_q = CTRL_RESET;
      tempo_q = TEMPO_RESET;
      div_q = DIV_RESET;
      grp_q = GRP_RESET;
      wt_lo_q = '0;
      wt_hi_q = '0;
      ln_lo_q = '0;
      ln_hi_q = '0;
      clear_run_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_strategies();
      test_tempo_extremes();
      test_disable();
      test_random();
      drain();
      if (errors == 0) begin
         $display("rhythm_step_envelope_sequencer_core: match");
      end else begin
         $display("rhythm_step_envelope_sequencer_core: mismatch");
      end
      $finish;
   end
endmodule
